[rtl/oneshot_periodic_timer_table_top_assert.svh]
// Assertion macros used by the checker file of the timer table.
`ifndef ONESHOT_PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH
`define ONESHOT_PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH

// Checked on every rising edge outside reset.
`define OPTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define OPTT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/optt_pkg.sv]
// Types and constants shared by the timer table modules.
package optt_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int TIME_BITS_DEF   = 48;
	localparam int DELAY_W         = 31;
	localparam int OUT_HANDLE_W    = 16;

	typedef enum logic [1:0] {
		ACT_SCHEDULE = 2'd0,
		ACT_CANCEL   = 2'd1,
		ACT_TICK     = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		KIND_SCHED  = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_FIRED  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_INSERT,
		ST_CSCAN,
		ST_TSCAN
	} state_t;

	typedef struct packed {
		logic [1:0]              action;
		logic [DELAY_W-1:0]      delay_ms;
		logic                    repeat_mode;
		logic [OUT_HANDLE_W-1:0] cancel_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]              result_kind;
		logic [OUT_HANDLE_W-1:0] timer_handle;
		logic                    was_pending;
		logic                    last_result;
	} rsp_t;

	typedef struct packed {
		action_t                 op;
		logic [DELAY_W-1:0]      delay_ms;
		logic                    repeat_mode;
		logic [OUT_HANDLE_W-1:0] cancel_handle;
	} op_t;

endpackage

[rtl/optt_front.sv]
// Front end: accepts request beats, drops unused codes and queues operations.
module optt_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  optt_pkg::req_t req,
	output logic          req_stall,
	output logic          op_valid,
	output optt_pkg::op_t op,
	input  logic          op_pop
);
	import optt_pkg::*;

	op_t        slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       known;
	logic       push;
	op_t        op_new;

	assign req_stall = (cnt_q == 2'd2);
	assign known     = (req.action == ACT_SCHEDULE) || (req.action == ACT_CANCEL) ||
	                   (req.action == ACT_TICK);
	// An unused action code is taken off the channel but never queued.
	assign push      = req_valid && !req_stall && known;

	always_comb begin
		op_new               = '0;
		op_new.op            = action_t'(req.action);
		op_new.delay_ms      = req.delay_ms;
		op_new.repeat_mode   = req.repeat_mode;
		op_new.cancel_handle = req.cancel_handle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (op_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, op_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= op_new;
	end

	assign op_valid = (cnt_q != 2'd0);
	assign op       = slot_q[rd_q];

endmodule

[rtl/optt_engine.sv]
// Back end: timer list kept in age order, swept, scanned and updated one entry a cycle unless rsp stalls it.
module optt_engine #(
	parameter int DEPTH       = optt_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = optt_pkg::HANDLE_BITS_DEF,
	parameter int TIME_BITS   = optt_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           op_valid,
	input  optt_pkg::op_t  op,
	output logic           op_pop,
	output logic           rsp_valid,
	output optt_pkg::rsp_t rsp,
	input  logic           rsp_stall
);
	import optt_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (HANDLE_BITS > OUT_HANDLE_W) ? HANDLE_BITS : OUT_HANDLE_W;

	state_t state_q, state_d;
	op_t    cur_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          ptr_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [HANDLE_BITS-1:0] next_h_q;
	logic [HANDLE_BITS-1:0] pend_q;
	logic                   pend_v_q;

	// Entry 0 is the newest timer; entries at or above count_q are never live.
	logic [DEPTH-1:0]       live_q;
	logic [DEPTH-1:0]       canc_q;
	logic [DEPTH-1:0]       fired_q;
	logic [HANDLE_BITS-1:0] handle_q [DEPTH];
	logic [TIME_BITS-1:0]   due_q    [DEPTH];
	logic [DELAY_W-1:0]     period_q [DEPTH];

	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [DEPTH-1:0] kill;
	logic [DEPTH-1:0] mask;
	logic             any_kill;
	logic [IW-1:0]    pidx;
	logic             at_end;
	logic             fire;
	logic             h_match;
	logic             out_free;
	logic [CMPW-1:0]  next_h_ext;
	logic [CMPW-1:0]  pend_ext;

	logic ld_op, compact, insert, now_inc, h_inc, t_fire, ptr_inc, c_hit, push;
	rsp_t push_d;

	always_comb begin
		for (int k = 0; k < DEPTH; k++)
			kill[k] = live_q[k] ? canc_q[k] : (CW'(k) < count_q);
		mask[0] = kill[0];
		for (int k = 1; k < DEPTH; k++)
			mask[k] = mask[k-1] | kill[k];
	end

	assign any_kill   = mask[DEPTH-1];
	assign pidx       = ptr_q[IW-1:0];
	assign at_end     = (ptr_q == count_q);
	assign fire       = live_q[pidx] && !canc_q[pidx] && (due_q[pidx] <= now_q);
	assign h_match    = live_q[pidx] &&
	                    (CMPW'(handle_q[pidx]) == CMPW'(cur_q.cancel_handle));
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign next_h_ext = CMPW'(next_h_q);
	assign pend_ext   = CMPW'(pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		op_pop  = 1'b0;
		ld_op   = 1'b0;
		compact = 1'b0;
		insert  = 1'b0;
		now_inc = 1'b0;
		h_inc   = 1'b0;
		t_fire  = 1'b0;
		ptr_inc = 1'b0;
		c_hit   = 1'b0;
		push    = 1'b0;
		push_d  = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_valid) begin
					op_pop = 1'b1;
					ld_op  = 1'b1;
					unique case (op.op)
						ACT_SCHEDULE: state_d = ST_SWEEP;
						ACT_TICK:     state_d = ST_SWEEP;
						ACT_CANCEL:   state_d = ST_CSCAN;
						default:      state_d = ST_IDLE;
					endcase
				end
			end
			ST_SWEEP: begin
				// Remove one cancelled or freed entry a cycle, closing the gap.
				if (any_kill) begin
					compact = 1'b1;
				end else if (cur_q.op == ACT_TICK) begin
					now_inc = 1'b1;
					state_d = ST_TSCAN;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				if (out_free) begin
					push                = 1'b1;
					h_inc               = 1'b1;
					push_d.timer_handle = next_h_ext[OUT_HANDLE_W-1:0];
					push_d.last_result  = 1'b1;
					if (count_q == CW'(DEPTH)) begin
						push_d.result_kind = KIND_FULL;
					end else begin
						push_d.result_kind = KIND_SCHED;
						insert             = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_CSCAN: begin
				if (at_end || h_match) begin
					if (out_free) begin
						push                = 1'b1;
						push_d.result_kind  = KIND_CANCEL;
						push_d.timer_handle = cur_q.cancel_handle;
						push_d.was_pending  = !at_end && !fired_q[pidx];
						push_d.last_result  = 1'b1;
						c_hit               = !at_end;
						state_d             = ST_IDLE;
					end
				end else begin
					ptr_inc = 1'b1;
				end
			end
			ST_TSCAN: begin
				// The handle that fired last is held back until it is known
				// whether it is the final result of this tick.
				push_d.result_kind  = KIND_FIRED;
				push_d.timer_handle = pend_ext[OUT_HANDLE_W-1:0];
				if (at_end) begin
					if (!pend_v_q) begin
						state_d = ST_IDLE;
					end else if (out_free) begin
						push               = 1'b1;
						push_d.last_result = 1'b1;
						state_d            = ST_IDLE;
					end
				end else if (fire) begin
					if (!pend_v_q || out_free) begin
						t_fire  = 1'b1;
						ptr_inc = 1'b1;
						push    = pend_v_q;
					end
				end else begin
					ptr_inc = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ptr_q       <= '0;
			now_q       <= '0;
			next_h_q    <= '0;
			pend_v_q    <= 1'b0;
			live_q      <= '0;
			canc_q      <= '0;
			fired_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ld_op) begin
				ptr_q    <= '0;
				pend_v_q <= 1'b0;
			end else if (ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (compact) begin
				count_q <= count_q - CW'(1);
				live_q  <= (live_q & ~mask) | ({1'b0, live_q[DEPTH-1:1]} & mask);
				canc_q  <= (canc_q & ~mask) | ({1'b0, canc_q[DEPTH-1:1]} & mask);
				fired_q <= (fired_q & ~mask) | ({1'b0, fired_q[DEPTH-1:1]} & mask);
			end
			if (insert) begin
				count_q <= count_q + CW'(1);
				live_q  <= {live_q[DEPTH-2:0], 1'b1};
				canc_q  <= {canc_q[DEPTH-2:0], 1'b0};
				fired_q <= {fired_q[DEPTH-2:0], 1'b0};
			end
			if (t_fire) begin
				fired_q[pidx] <= 1'b1;
				pend_v_q      <= 1'b1;
				if (period_q[pidx] == '0)
					live_q[pidx] <= 1'b0;
			end
			if (c_hit)
				canc_q[pidx] <= 1'b1;
			if (now_inc)
				now_q <= now_q + TIME_BITS'(1);
			if (h_inc)
				next_h_q <= next_h_q + HANDLE_BITS'(1);
			if (push)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_op)
			cur_q <= op;
		if (compact) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				if (mask[k]) begin
					handle_q[k] <= handle_q[k+1];
					due_q[k]    <= due_q[k+1];
					period_q[k] <= period_q[k+1];
				end
			end
		end
		if (insert) begin
			for (int k = DEPTH - 1; k > 0; k--) begin
				handle_q[k] <= handle_q[k-1];
				due_q[k]    <= due_q[k-1];
				period_q[k] <= period_q[k-1];
			end
			handle_q[0] <= next_h_q;
			due_q[0]    <= now_q + TIME_BITS'(cur_q.delay_ms);
			period_q[0] <= (cur_q.repeat_mode && (cur_q.delay_ms != '0)) ?
			               cur_q.delay_ms : '0;
		end
		if (t_fire) begin
			pend_q <= handle_q[pidx];
			if (period_q[pidx] != '0)
				due_q[pidx] <= due_q[pidx] + TIME_BITS'(period_q[pidx]);
		end
		if (push)
			rsp_q <= push_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/oneshot_periodic_timer_table_top.sv]
// Top level of the one-shot and periodic timer table.
//
// The req channel carries one operation per beat: schedule (delay and repeat
// flag), cancel (handle) or a one millisecond tick. Beats with the unused
// action code are taken and dropped. The rsp channel returns one beat per
// result; last_result marks the final beat caused by an operation. A tick
// returns one beat for each timer that fires, newest first, or none at all.
// Accepted operations wait in a two-entry queue in front of the engine, so
// req keeps flowing while a result is stalled on rsp.
// Per operation, a schedule sweeps out removed entries and then inserts, a
// cancel scans for its handle and a tick sweeps and then scans; the engine
// works through the age-ordered list one entry a cycle unless rsp holds it.
// A stall on rsp holds the result register and, once a further result is
// ready, stops the engine; req then stalls when the queue has filled.
// Reset empties the table, clears the clock and the handle counter, and
// drops queued operations and a waiting result.
module oneshot_periodic_timer_table_top #(
	parameter int DEPTH       = optt_pkg::DEPTH_DEF,
	parameter int HANDLE_BITS = optt_pkg::HANDLE_BITS_DEF,
	parameter int TIME_BITS   = optt_pkg::TIME_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  optt_pkg::req_t req,
	output logic           req_stall,
	output logic           rsp_valid,
	output optt_pkg::rsp_t rsp,
	input  logic           rsp_stall
);
	import optt_pkg::*;

	op_t  op;
	logic op_valid;
	logic op_pop;

	optt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop)
	);

	optt_engine #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.op_pop    (op_pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall)
	);

endmodule

[rtl/optt_checker.sv]
// Port-level checker for the timer table, bound to the top level.
`include "oneshot_periodic_timer_table_top_assert.svh"

module optt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           rsp_valid,
	input optt_pkg::rsp_t rsp,
	input logic           rsp_stall
);
	import optt_pkg::*;

	logic single_kind;

	// Every kind but a fired timer is the only beat of its operation.
	assign single_kind = (rsp.result_kind != KIND_FIRED);

	`OPTT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "rsp moved")
	`OPTT_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp_valid, "rsp valid during reset")
	`OPTT_ASSERT(a_single_last, rsp_valid && single_kind |-> rsp.last_result, "no last mark")
	`OPTT_ASSERT(a_pending_kind, rsp_valid && rsp.was_pending |-> single_kind, "stray pending")
	`OPTT_ASSERT(a_req_quiet_rst, $rose(arst_n) |-> !req_stall, "stall after reset")

endmodule

bind oneshot_periodic_timer_table_top optt_checker u_optt_checker (.*);

[dv/tb_oneshot_periodic_timer_table_top.sv]
// Self-checking timer table bench: directed beats, then random schedule, cancel, tick.
module tb_oneshot_periodic_timer_table_top;
	import optt_pkg::*;

	localparam int NSLOT = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Keeps its own copy of the timer table and queues the beats it predicts.
	class timer_scoreboard;
		bit        used[NSLOT];
		bit        cxl[NSLOT];
		bit        fired[NSLOT];
		bit [15:0] hnd[NSLOT];
		bit [47:0] due[NSLOT];
		bit [30:0] per[NSLOT];
		int        age[NSLOT];
		bit [47:0] clock_ms;
		bit [15:0] handle_ctr;
		rsp_t      pending_rsp[$];
		int        errors;
		int        checked;
		int        ticks_fired;

		function void release_slot(int s);
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && i != s && age[i] > age[s]) age[i]--;
			used[s] = 0;
			cxl[s] = 0;
			fired[s] = 0;
		endfunction

		function void sweep();
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && cxl[i]) release_slot(i);
		endfunction

		function void push(logic [1:0] kind, logic [15:0] h, logic p, logic last);
			rsp_t r;
			r.result_kind = kind;
			r.timer_handle = h;
			r.was_pending = p;
			r.last_result = last;
			pending_rsp.push_back(r);
		endfunction

		function void note_request(req_t q);
			int fs;
			int hit;
			int order[$];
			int n;
			fs = -1;
			hit = -1;
			n = 0;
			if (q.action == ACT_SCHEDULE) begin
				sweep();
				for (int i = 0; i < NSLOT; i++)
					if (!used[i] && fs < 0) fs = i;
				if (fs < 0) begin
					push(KIND_FULL, handle_ctr, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < NSLOT; i++)
						if (used[i]) age[i]++;
					hnd[fs] = handle_ctr;
					due[fs] = clock_ms + q.delay_ms;
					per[fs] = (q.repeat_mode && q.delay_ms != 0) ? q.delay_ms : '0;
					age[fs] = 0;
					cxl[fs] = 0;
					fired[fs] = 0;
					used[fs] = 1;
					push(KIND_SCHED, handle_ctr, 1'b0, 1'b1);
				end
				handle_ctr++;
			end else if (q.action == ACT_CANCEL) begin
				for (int i = 0; i < NSLOT; i++)
					if (used[i] && hnd[i] == q.cancel_handle && (hit < 0 || age[i] < age[hit]))
						hit = i;
				if (hit >= 0) cxl[hit] = 1;
				push(KIND_CANCEL, q.cancel_handle, hit >= 0 && !fired[hit], 1'b1);
			end else if (q.action == ACT_TICK) begin
				sweep();
				clock_ms++;
				for (int r = 0; r < NSLOT; r++)
					for (int i = 0; i < NSLOT; i++)
						if (used[i] && age[i] == r) order.push_back(i);
				foreach (order[k]) begin
					int s;
					s = order[k];
					if (used[s] && !cxl[s] && due[s] <= clock_ms) begin
						push(KIND_FIRED, hnd[s], 1'b0, 1'b0);
						n++;
						fired[s] = 1;
						if (per[s] == 0) release_slot(s);
						else due[s] = due[s] + per[s];
					end
				end
				if (n > 0) pending_rsp[$].last_result = 1'b1;
				ticks_fired += n;
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			checked++;
			if (pending_rsp.size() == 0) begin
				report_mismatch("result beat with nothing expected");
				return;
			end
			want = pending_rsp.pop_front();
			if (got.result_kind !== want.result_kind) report_mismatch("result_kind");
			if (got.timer_handle !== want.timer_handle) report_mismatch("timer_handle");
			if (got.was_pending !== want.was_pending) report_mismatch("was_pending");
			if (got.last_result !== want.last_result) report_mismatch("last_result");
		endfunction

		function void report_mismatch(string what);
			errors++;
			$display("MISMATCH at result %0d: %s", checked, what);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	req_t req;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;
	logic rsp_stall;

	timer_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	longint cycles = 0;
	int n_sched, n_cancel, n_tick;

	oneshot_periodic_timer_table_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req(req),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp(rsp),
		.rsp_stall(rsp_stall)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: check accepted beats and stall at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) sb.check_result(rsp);
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Drives one beat and holds it until the block takes it.
	task automatic send_beat(logic [1:0] act, logic [30:0] dly, logic rep, logic [15:0] h);
		req_t q;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		q.action = act;
		q.delay_ms = dly;
		q.repeat_mode = rep;
		q.cancel_handle = h;
		req <= q;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sb.note_request(q);
		case (act)
			ACT_SCHEDULE: n_sched++;
			ACT_CANCEL: n_cancel++;
			ACT_TICK: n_tick++;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Mostly small delays so that timers fire; a few huge ones to cover high bits.
	task automatic random_beat();
		int pick;
		logic [30:0] d;
		logic [15:0] h;
		pick = $urandom_range(99);
		d = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(6));
		h = ($urandom_range(3) == 0) ? 16'($urandom) : sb.handle_ctr - 16'($urandom_range(1, 8));
		if (pick < 40) send_beat(ACT_SCHEDULE, d, 1'($urandom_range(1)), 16'($urandom));
		else if (pick < 55) send_beat(ACT_CANCEL, 31'($urandom), 1'($urandom_range(1)), h);
		else if (pick < 97)
			send_beat(ACT_TICK, 31'($urandom), 1'($urandom_range(1)), 16'($urandom));
		else send_beat(ACT_UNUSED, 31'($urandom), 1'($urandom_range(1)), 16'($urandom));
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero-delay repeat, full table, cancels, unused action.
		send_beat(ACT_SCHEDULE, 31'h7fffffff, 1'b1, 16'hffff);
		send_beat(ACT_SCHEDULE, 31'd0, 1'b1, 16'h0000);
		send_beat(ACT_SCHEDULE, 31'd1, 1'b1, 16'h0000);
		send_beat(ACT_SCHEDULE, 31'd2, 1'b0, 16'h0000);
		send_beat(ACT_TICK, 31'd0, 1'b0, 16'h0000);
		send_beat(ACT_TICK, 31'h7fffffff, 1'b1, 16'hffff);
		send_beat(ACT_CANCEL, 31'd0, 1'b0, 16'd2);
		send_beat(ACT_CANCEL, 31'd0, 1'b0, 16'd2);
		send_beat(ACT_CANCEL, 31'd0, 1'b0, 16'd0);
		send_beat(ACT_CANCEL, 31'h7fffffff, 1'b1, 16'hffff);
		send_beat(ACT_UNUSED, 31'h7fffffff, 1'b1, 16'hffff);
		for (int i = 0; i < 16; i++) send_beat(ACT_SCHEDULE, 31'd3, i[0], 16'h0);
		send_beat(ACT_TICK, 31'd0, 1'b0, 16'h0);
		send_beat(ACT_TICK, 31'd0, 1'b0, 16'h0);
		wait_drained();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 84 : 0;
			recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 35 : 0;
			for (int k = 0; k < 30; k++) random_beat();
			// Hold off until the table has answered everything sent so far.
			wait_drained();
		end

		// Wait once more until every predicted result beat has been received.
		wait_drained();
		$display("Covered %0d schedules, %0d cancels, %0d ticks; %0d timers fired.",
			n_sched, n_cancel, n_tick, sb.ticks_fired);
		$display("Checked %0d result beats with %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/optt_pkg.sv
rtl/optt_front.sv
rtl/optt_engine.sv
rtl/oneshot_periodic_timer_table_top.sv
rtl/optt_checker.sv
dv/tb_oneshot_periodic_timer_table_top.sv
